FILE: rtl/cmph_pkg.sv
// ----------------------------------------------------------------------------
// cmph_pkg
// Shared types, widths and the arctangent table for the compass heading block.
// ----------------------------------------------------------------------------
package cmph_pkg;

    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int FIELD_W    = 17;
    localparam int HEAD_W     = 15;
    localparam int XY_W       = 28;
    localparam int Z_W        = 26;
    localparam int TBL_IDX_W  = 5;
    localparam int TBL_LEN    = 24;
    localparam int AXES       = 3;

    localparam logic [GAIN_W-1:0]       GAIN_RESET  = 16'd6013;
    localparam logic signed [Z_W-1:0]   DEG180_Q16  = 26'sd11796480;
    localparam logic signed [FIELD_W-1:0] FULL_TURN = 17'sd23040;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_ROT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctrl_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [TBL_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/cmph_mul.sv
// ----------------------------------------------------------------------------
// cmph_mul
// Bit-serial signed-by-unsigned multiplier, one gain bit per cycle while
// ctrl.step is high, with round-half-up to Q.4 and saturation to 17 bits.
// ----------------------------------------------------------------------------
module cmph_mul
    import cmph_pkg::*;
(
    input  logic                       clk,
    input  mul_ctrl_t                  ctrl,
    input  logic [BYTE_W-1:0]          raw_high,
    input  logic [BYTE_W-1:0]          raw_low,
    input  logic [GAIN_W-1:0]          gain,
    output logic signed [FIELD_W-1:0]  field
);

    logic signed [RAW_W-1:0]   raw_reg;
    logic signed [RAW_W:0]     hi_reg;
    logic signed [RAW_W:0]     hi_next;
    logic [GAIN_W-1:0]         lo_reg;
    logic [GAIN_W-1:0]         lo_next;
    logic signed [RAW_W+1:0]   sum;
    logic signed [RAW_W+GAIN_W:0]   prod;
    logic signed [RAW_W+GAIN_W+1:0] prod_r;
    logic signed [RAW_W+GAIN_W-11:0] q;

    always_comb
    begin
        sum     = {hi_reg[RAW_W], hi_reg}
                + (lo_reg[0] ? {{2{raw_reg[RAW_W-1]}}, raw_reg} : '0);
        hi_next = sum[RAW_W+1:1];
        lo_next = {sum[0], lo_reg[GAIN_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            raw_reg <= {raw_high, raw_low};
            hi_reg  <= '0;
            lo_reg  <= gain;
        end
        else if (ctrl.step)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_comb
    begin
        prod   = {hi_reg, lo_reg};
        prod_r = {prod[RAW_W+GAIN_W], prod} + 34'sd2048;
        q      = prod_r[RAW_W+GAIN_W+1:12];
        if (q > 22'sd65535)
            field = 17'sd65535;
        else if (q < -22'sd65536)
            field = -17'sd65536;
        else
            field = q[FIELD_W-1:0];
    end

endmodule

FILE: rtl/cmph_cordic.sv
// ----------------------------------------------------------------------------
// cmph_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle, giving
// atan2(y, x) in 1/64 degree wrapped to 0 up to but not including 360.
// ----------------------------------------------------------------------------
module cmph_cordic
    import cmph_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [FIELD_W-1:0]  fx,
    input  logic signed [FIELD_W-1:0]  fy,
    output logic                       done,
    output logic [HEAD_W-1:0]          heading
);

    localparam int STEPS_USED = (CORDIC_STEPS > TBL_LEN) ? TBL_LEN : CORDIC_STEPS;
    localparam int CNT_W      = (STEPS_USED > 1) ? $clog2(STEPS_USED) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS_USED - 1);

    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic                    zero_reg;

    logic signed [XY_W-1:0]  x0;
    logic signed [XY_W-1:0]  y0;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [Z_W-1:0]   ang;
    logic signed [Z_W:0]     z_rnd;
    logic signed [FIELD_W-1:0] h;
    logic signed [FIELD_W-1:0] h_wrap;

    always_comb
    begin
        x0  = {{3{fx[FIELD_W-1]}}, fx, 8'd0};
        y0  = {{3{fy[FIELD_W-1]}}, fy, 8'd0};
        dx  = y_reg >>> cnt_reg;
        dy  = x_reg >>> cnt_reg;
        ang = atan_q16(TBL_IDX_W'(cnt_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (fx == '0) && (fy == '0);
            if (fx[FIELD_W-1])
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= DEG180_Q16;
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[XY_W-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
        end
    end

    always_comb
    begin
        z_rnd = {z_reg[Z_W-1], z_reg} + 27'sd512;
        h     = z_rnd[Z_W:10];
        if (h < 0)
            h_wrap = h + FULL_TURN;
        else if (h >= FULL_TURN)
            h_wrap = h - FULL_TURN;
        else
            h_wrap = h;
        heading = zero_reg ? '0 : h_wrap[HEAD_W-1:0];
        done    = done_reg;
    end

endmodule

FILE: rtl/compass_heading_with_offset_tracking_top.sv
// ----------------------------------------------------------------------------
// compass_heading_with_offset_tracking_top
// Magnetometer sample to scaled field, heading and hard-iron offsets.
// ----------------------------------------------------------------------------
// One beat on the input channel (in_valid/in_ready) carries the six raw
// sample bytes in X, Z, Y big-endian order. One beat on the output channel
// (out_valid/out_ready) returns the three Q.4 fields, the heading in 1/64
// degree and the running (max+min)/2 offsets per axis.
// The gain is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The three bit-serial multipliers work through the gain one bit at a time,
// then the shared iterative CORDIC runs, with CORDIC_STEPS capped at 24.
// out_valid and in_ready rise at the same edge, so the block takes no new
// sample until the last result has been loaded into the output register.
// A result waiting in the output register does not block acceptance of the
// next sample; only when that next result is finished and the output is still
// held does the block wait for out_ready.
// Reset clears the min/max trackers to zero, loads the gain with 6013 and
// drops out_valid.
// ----------------------------------------------------------------------------
module compass_heading_with_offset_tracking_top
    import cmph_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [GAIN_W-1:0]          cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [BYTE_W-1:0]          x_high,
    input  logic [BYTE_W-1:0]          x_low,
    input  logic [BYTE_W-1:0]          z_high,
    input  logic [BYTE_W-1:0]          z_low,
    input  logic [BYTE_W-1:0]          y_high,
    input  logic [BYTE_W-1:0]          y_low,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [FIELD_W-1:0]  field_x,
    output logic signed [FIELD_W-1:0]  field_y,
    output logic signed [FIELD_W-1:0]  field_z,
    output logic [HEAD_W-1:0]          heading,
    output logic signed [FIELD_W-1:0]  offset_x,
    output logic signed [FIELD_W-1:0]  offset_y,
    output logic signed [FIELD_W-1:0]  offset_z
);

    localparam int MUL_CNT_W = $clog2(GAIN_W);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(GAIN_W - 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic [MUL_CNT_W-1:0]      mul_cnt_reg;
    logic [GAIN_W-1:0]         gain_scale_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    mul_ctrl_t                 mul_ctrl;
    logic                      accept;
    logic                      cordic_start;
    logic                      cordic_done;
    logic                      out_load;
    logic [HEAD_W-1:0]         cordic_heading;

    logic signed [FIELD_W-1:0] fld [AXES];
    logic signed [FIELD_W-1:0] min_reg [AXES];
    logic signed [FIELD_W-1:0] max_reg [AXES];
    logic signed [FIELD_W-1:0] min_next [AXES];
    logic signed [FIELD_W-1:0] max_next [AXES];
    logic signed [FIELD_W:0]   off_sum [AXES];

    logic signed [FIELD_W-1:0] field_x_reg;
    logic signed [FIELD_W-1:0] field_y_reg;
    logic signed [FIELD_W-1:0] field_z_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic signed [FIELD_W-1:0] offset_x_reg;
    logic signed [FIELD_W-1:0] offset_y_reg;
    logic signed [FIELD_W-1:0] offset_z_reg;

    cmph_mul u_mul_x (
        .clk      (clk),
        .ctrl     (mul_ctrl),
        .raw_high (x_high),
        .raw_low  (x_low),
        .gain     (gain_scale_reg),
        .field    (fld[AX_X])
    );

    cmph_mul u_mul_y (
        .clk      (clk),
        .ctrl     (mul_ctrl),
        .raw_high (y_high),
        .raw_low  (y_low),
        .gain     (gain_scale_reg),
        .field    (fld[AX_Y])
    );

    cmph_mul u_mul_z (
        .clk      (clk),
        .ctrl     (mul_ctrl),
        .raw_high (z_high),
        .raw_low  (z_low),
        .gain     (gain_scale_reg),
        .field    (fld[AX_Z])
    );

    cmph_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .fx      (fld[AX_X]),
        .fy      (fld[AX_Y]),
        .done    (cordic_done),
        .heading (cordic_heading)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_scale_reg <= GAIN_RESET;
        else if (cfg_wr_en)
            gain_scale_reg <= cfg_wr_data;
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cordic_start   = 1'b0;
        out_load       = 1'b0;
        mul_ctrl.load  = 1'b0;
        mul_ctrl.step  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                mul_ctrl.load = in_valid;
                if (in_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                mul_ctrl.step = 1'b1;
                if (mul_cnt_reg == MUL_LAST)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cordic_start = 1'b1;
                state_next   = S_ROT;
            end
            S_ROT:
            begin
                if (cordic_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        accept = in_valid && in_ready;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                mul_cnt_reg <= '0;
            else if (mul_ctrl.step)
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
        end
    end

    // running extremes and offsets, one lane per axis
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            min_next[k] = (fld[k] < min_reg[k]) ? fld[k] : min_reg[k];
            max_next[k] = (fld[k] > max_reg[k]) ? fld[k] : max_reg[k];
            off_sum[k]  = {max_next[k][FIELD_W-1], max_next[k]}
                        + {min_next[k][FIELD_W-1], min_next[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                min_reg[k] <= '0;
                max_reg[k] <= '0;
            end
        end
        else if (out_load)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                min_reg[k] <= min_next[k];
                max_reg[k] <= max_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            field_x_reg  <= fld[AX_X];
            field_y_reg  <= fld[AX_Y];
            field_z_reg  <= fld[AX_Z];
            heading_reg  <= cordic_heading;
            offset_x_reg <= off_sum[AX_X][FIELD_W:1];
            offset_y_reg <= off_sum[AX_Y][FIELD_W:1];
            offset_z_reg <= off_sum[AX_Z][FIELD_W:1];
        end
    end

    assign out_valid = out_valid_reg;
    assign field_x   = field_x_reg;
    assign field_y   = field_y_reg;
    assign field_z   = field_z_reg;
    assign heading   = heading_reg;
    assign offset_x  = offset_x_reg;
    assign offset_y  = offset_y_reg;
    assign offset_z  = offset_z_reg;

    // extremes start at zero, so min never goes above it nor max below it
    a_extreme_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !min_reg[AX_X][FIELD_W-1] |-> min_reg[AX_X] == '0)
        else $error("x minimum above zero");

    a_max_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !max_reg[AX_Y][FIELD_W-1] || max_reg[AX_Y] == '0)
        else $error("y maximum below zero");

    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MUL && mul_cnt_reg == '0)
        else $error("multiply did not start after input beat");

    a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> state_reg == S_ROT)
        else $error("rotation finished outside the rotate state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("output beat raised outside the done state");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compass heading block: raw samples go in with
// random gaps and output back-pressure, a bit-true tracker predicts the scaled
// fields, heading and hard-iron offsets, and every output beat is compared.
// ----------------------------------------------------------------------------
module tb
    import cmph_pkg::*;
();

    localparam int CORDIC_STEPS = 16;
    localparam longint HALF_TURN_Q16 = 11796480;
    localparam longint TURN_64THS = 23040;
    localparam longint FIELD_MAX = 65535;
    localparam longint FIELD_MIN = -65536;
    localparam int PHASES = 8;

    typedef struct {
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
        logic signed [FIELD_W-1:0] fz;
        logic [HEAD_W-1:0]         hd;
        logic signed [FIELD_W-1:0] ox;
        logic signed [FIELD_W-1:0] oy;
        logic signed [FIELD_W-1:0] oz;
    } compass_reading_t;

    class heading_offset_tracker;
        compass_reading_t expected_readings[$];
        logic [GAIN_W-1:0] gain;
        longint axis_lo[AXES];
        longint axis_hi[AXES];
        longint atan_deg[TBL_LEN];
        int errors;

        function new();
            gain = GAIN_RESET;
            errors = 0;
            for (int k = 0; k < AXES; k++)
            begin
                axis_lo[k] = 0;
                axis_hi[k] = 0;
            end
            atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function longint scale_axis(input logic [BYTE_W-1:0] hb, input logic [BYTE_W-1:0] lb);
            longint prod;
            longint q;
            prod = longint'($signed({hb, lb})) * longint'(gain);
            q = (prod + 2048) >>> 12;
            if (q > FIELD_MAX)
                q = FIELD_MAX;
            if (q < FIELD_MIN)
                q = FIELD_MIN;
            return q;
        endfunction

        function longint heading_of(input longint fx, input longint fy);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint h;
            int n;
            if (fx == 0 && fy == 0)
                return 0;
            x = fx * 256;
            y = fy * 256;
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF_TURN_Q16;
            end
            n = (CORDIC_STEPS > TBL_LEN) ? TBL_LEN : CORDIC_STEPS;
            for (int i = 0; i < n; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_deg[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_deg[i];
                end
            end
            h = (z + 512) >>> 10;
            while (h < 0)
                h = h + TURN_64THS;
            while (h >= TURN_64THS)
                h = h - TURN_64THS;
            return h;
        endfunction

        function void note_sample(input logic [BYTE_W-1:0] xh, input logic [BYTE_W-1:0] xl,
                                  input logic [BYTE_W-1:0] zh, input logic [BYTE_W-1:0] zl,
                                  input logic [BYTE_W-1:0] yh, input logic [BYTE_W-1:0] yl);
            longint f[AXES];
            longint off[AXES];
            compass_reading_t r;
            f[AX_X] = scale_axis(xh, xl);
            f[AX_Z] = scale_axis(zh, zl);
            f[AX_Y] = scale_axis(yh, yl);
            for (int k = 0; k < AXES; k++)
            begin
                if (f[k] < axis_lo[k])
                    axis_lo[k] = f[k];
                if (f[k] > axis_hi[k])
                    axis_hi[k] = f[k];
                off[k] = (axis_hi[k] + axis_lo[k]) >>> 1;
            end
            r.fx = f[AX_X][FIELD_W-1:0];
            r.fy = f[AX_Y][FIELD_W-1:0];
            r.fz = f[AX_Z][FIELD_W-1:0];
            r.hd = HEAD_W'(heading_of(f[AX_X], f[AX_Y]));
            r.ox = off[AX_X][FIELD_W-1:0];
            r.oy = off[AX_Y][FIELD_W-1:0];
            r.oz = off[AX_Z][FIELD_W-1:0];
            expected_readings.push_back(r);
        endfunction

        function void compare_field(input string name, input longint want, input longint seen);
            if (want != seen)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_reading(input compass_reading_t seen);
            compass_reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("output beat with no sample outstanding");
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("field_x", want.fx, seen.fx);
            compare_field("field_y", want.fy, seen.fy);
            compare_field("field_z", want.fz, seen.fz);
            compare_field("heading", want.hd, seen.hd);
            compare_field("offset_x", want.ox, seen.ox);
            compare_field("offset_y", want.oy, seen.oy);
            compare_field("offset_z", want.oz, seen.oz);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [GAIN_W-1:0]         cfg_wr_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [BYTE_W-1:0]         x_high;
    logic [BYTE_W-1:0]         x_low;
    logic [BYTE_W-1:0]         z_high;
    logic [BYTE_W-1:0]         z_low;
    logic [BYTE_W-1:0]         y_high;
    logic [BYTE_W-1:0]         y_low;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic [HEAD_W-1:0]         heading;
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
    logic signed [FIELD_W-1:0] offset_z;

    heading_offset_tracker tracker;
    compass_reading_t      seen_reading;
    logic                  calm;
    logic [GAIN_W-1:0]     gain_plan[PHASES];

    compass_heading_with_offset_tracking_top #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_high      (x_high),
        .x_low       (x_low),
        .z_high      (z_high),
        .z_low       (z_low),
        .y_high      (y_high),
        .y_low       (y_low),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_x     (field_x),
        .field_y     (field_y),
        .field_z     (field_z),
        .heading     (heading),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .offset_z    (offset_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_reading.fx = field_x;
            seen_reading.fy = field_y;
            seen_reading.fz = field_z;
            seen_reading.hd = heading;
            seen_reading.ox = offset_x;
            seen_reading.oy = offset_y;
            seen_reading.oz = offset_z;
            tracker.check_reading(seen_reading);
        end
    end

    // receiver back-pressure
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
                stall = 0;
            else if (stall == 0 && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 13);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
                out_ready = 1'b1;
        end
    end

    task automatic send_sample(input logic [RAW_W-1:0] xr, input logic [RAW_W-1:0] zr,
                               input logic [RAW_W-1:0] yr);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        {x_high, x_low} = xr;
        {z_high, z_low} = zr;
        {y_high, y_low} = yr;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_sample(x_high, x_low, z_high, z_low, y_high, y_low);
    endtask

    task automatic drain_readings();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        drain_readings();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = g;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        tracker.gain = g;
    endtask

    function automatic logic [RAW_W-1:0] random_axis();
        int s;
        logic [RAW_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = RAW_W'($urandom_range(0, 65535));
            1:
            begin
                s = int'($urandom_range(0, 600)) - 300;
                v = s[RAW_W-1:0];
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'hFFFF;
                    3: v = 16'h0001;
                    default: v = 16'h0000;
                endcase
            end
            3:
            begin
                s = int'($urandom_range(0, 8000)) - 4000;
                v = s[RAW_W-1:0];
            end
            default: v = RAW_W'($urandom());
        endcase
        return v;
    endfunction

    initial
    begin
        int count;
        tracker = new();
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        {x_high, x_low, z_high, z_low, y_high, y_low} = '0;
        gain_plan[0] = 16'hFFFF;
        gain_plan[1] = 16'h0000;
        gain_plan[2] = 16'h0001;
        gain_plan[3] = 16'd4096;
        gain_plan[4] = GAIN_W'($urandom_range(0, 65535));
        gain_plan[5] = GAIN_W'($urandom_range(8000, 40000));
        gain_plan[6] = GAIN_RESET;
        gain_plan[7] = GAIN_W'($urandom_range(1000, 12000));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset gain
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'h7FFF);
        send_sample(16'h0000, 16'hFFFF, 16'h8000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(-16'sd1000, 16'h0100, 16'd1000);
        send_sample(-16'sd1000, 16'h0200, -16'sd1000);
        send_sample(16'd1000, 16'h0300, -16'sd1000);
        send_sample(16'd1000, 16'h0400, 16'd1000);
        send_sample(-16'sd500, 16'h0000, 16'h0000);
        send_sample(16'h0001, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(16'h00FF, 16'hFF00, 16'hFF00);
        send_sample(16'h5555, 16'h3333, 16'hAAAA);
        send_sample(16'd3, 16'd7, -16'sd3);

        for (int p = 0; p < PHASES; p++)
        begin
            write_gain(gain_plan[p]);
            if (p == 0)
            begin
                // saturation at full-scale gain
                send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
                send_sample(16'h8000, 16'h7FFF, 16'h8000);
                send_sample(16'h0001, 16'hFFFF, 16'hFFFF);
                send_sample(16'h8000, 16'h0000, 16'h0000);
            end
            count = (gain_plan[p] == 16'h0000) ? 20 : 120;
            for (int k = 0; k < count; k++)
            begin
                if (p == PHASES - 1)
                    calm = 1'b1;
                else if (k % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (p == 4 && k == 60)
                    drain_readings();
                send_sample(random_axis(), random_axis(), random_axis());
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        calm = 1'b1;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: compass_heading_with_offset_tracking_top.f
rtl/cmph_pkg.sv
rtl/cmph_mul.sv
rtl/cmph_cordic.sv
rtl/compass_heading_with_offset_tracking_top.sv
dv/tb.sv
